/* rtl/core/apt_pkg.sv */
package apt_pkg;

  // Field widths.
  localparam int AXIS_W  = 16;
  localparam int SQR_W   = 31;              // one axis squared
  localparam int SUM_W   = 32;              // y*y + z*z
  localparam int RAD_W   = SUM_W + 16;      // radicand, 8 fraction bits on the root
  localparam int ROOT_W  = RAD_W / 2;       // floor square root
  localparam int CW      = 28;              // CORDIC x and y datapath
  localparam int ACC_W   = 28;              // angle accumulator, micro-degrees
  localparam int ANG_W   = 27;              // one arctangent table entry
  localparam int MAG_W   = 27;              // rounded magnitude before division
  localparam int Q_W     = 14;              // quotient in hundredths of a degree
  localparam int PITCH_W = 15;
  localparam int THR_W   = 14;

  localparam int ATAN_STEPS = 24;

  // Conversion from micro-degrees to hundredths, rounded to nearest.
  localparam logic [Q_W-1:0]   DIVISOR     = 14'd10000;
  localparam logic [MAG_W-1:0] HALF_DIV    = 27'd5000;
  localparam int               RECIP_SHIFT = 40;
  localparam logic [MAG_W-1:0] RECIP       = MAG_W'((64'd1 << RECIP_SHIFT) / 64'd10000);

  localparam logic [Q_W-1:0]   PITCH_MAX   = 14'd9000;
  localparam logic [THR_W-1:0] THR_RESET   = 14'd4500;

  // Special cases decided early and carried down the pipeline.
  typedef struct packed {
    logic x_zero;
    logic s_zero;
    logic x_neg;
  } meta_t;

  // atan(2^-i) in micro-degrees, rounded to nearest.
  function automatic logic [ANG_W-1:0] atan_udeg(input int i);
    logic [ANG_W-1:0] v;
    case (i)
      0:  v = 27'd45000000;
      1:  v = 27'd26565051;
      2:  v = 27'd14036243;
      3:  v = 27'd7125016;
      4:  v = 27'd3576334;
      5:  v = 27'd1789911;
      6:  v = 27'd895174;
      7:  v = 27'd447614;
      8:  v = 27'd223811;
      9:  v = 27'd111906;
      10: v = 27'd55953;
      11: v = 27'd27976;
      12: v = 27'd13988;
      13: v = 27'd6994;
      14: v = 27'd3497;
      15: v = 27'd1749;
      16: v = 27'd874;
      17: v = 27'd437;
      18: v = 27'd219;
      19: v = 27'd109;
      20: v = 27'd55;
      21: v = 27'd27;
      22: v = 27'd14;
      23: v = 27'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/apt_isqrt.sv */
// Pipelined floor square root, one result bit per stage.
module apt_isqrt (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_vld,
  input  logic [apt_pkg::SUM_W-1:0]        in_sum,
  input  logic signed [apt_pkg::AXIS_W-1:0] in_x,
  input  apt_pkg::meta_t                   in_meta,
  output logic                             out_vld,
  output logic [apt_pkg::ROOT_W-1:0]       out_root,
  output logic signed [apt_pkg::AXIS_W-1:0] out_x,
  output apt_pkg::meta_t                   out_meta
);

  localparam int N  = apt_pkg::ROOT_W;
  localparam int RW = apt_pkg::RAD_W;

  logic [RW-1:0]                      rem_r    [N];
  logic [N-1:0]                       root_r   [N];
  logic signed [apt_pkg::AXIS_W-1:0]  x_r      [N];
  apt_pkg::meta_t                     meta_r   [N];
  logic                               vld_r    [N];

  logic [RW-1:0]                      rem_nxt  [N];
  logic [N-1:0]                       root_nxt [N];

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int K = N - 1 - j;

    logic [RW-1:0]                     rem_in;
    logic [N-1:0]                      root_in;
    logic signed [apt_pkg::AXIS_W-1:0] x_in;
    apt_pkg::meta_t                    meta_in;
    logic                              vld_in;
    logic [RW-1:0]                     trial;

    if (j == 0) begin : g_first
      assign rem_in  = {in_sum, {(RW - apt_pkg::SUM_W){1'b0}}};
      assign root_in = '0;
      assign x_in    = in_x;
      assign meta_in = in_meta;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign x_in    = x_r[j-1];
      assign meta_in = meta_r[j-1];
      assign vld_in  = vld_r[j-1];
    end

    // Trial subtrahend 2*root*2^K + 2^(2K).
    always_comb begin
      trial = ({{(RW - N){1'b0}}, root_in} << (K + 1)) + (RW'(1) << (2 * K));
      if (rem_in >= trial) begin
        rem_nxt[j]  = rem_in - trial;
        root_nxt[j] = root_in | (N'(1) << K);
      end else begin
        rem_nxt[j]  = rem_in;
        root_nxt[j] = root_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt[j];
        root_r[j] <= root_nxt[j];
        x_r[j]    <= x_in;
        meta_r[j] <= meta_in;
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_root = root_r[N-1];
  assign out_x    = x_r[N-1];
  assign out_meta = meta_r[N-1];

endmodule

/* rtl/core/apt_cordic.sv */
// Vectoring CORDIC, one micro-rotation per stage.
module apt_cordic #(
  parameter int ITERATIONS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic [apt_pkg::ROOT_W-1:0]        in_root,
  input  logic signed [apt_pkg::AXIS_W-1:0] in_x,
  input  apt_pkg::meta_t                    in_meta,
  output logic                              out_vld,
  output logic signed [apt_pkg::ACC_W-1:0]  out_acc,
  output apt_pkg::meta_t                    out_meta
);

  localparam int CW    = apt_pkg::CW;
  localparam int AW    = apt_pkg::ACC_W;
  localparam int STEPS = (ITERATIONS < apt_pkg::ATAN_STEPS) ? ITERATIONS : apt_pkg::ATAN_STEPS;

  logic signed [CW-1:0] cx_r   [STEPS];
  logic signed [CW-1:0] cy_r   [STEPS];
  logic signed [AW-1:0] acc_r  [STEPS];
  apt_pkg::meta_t       meta_r [STEPS];
  logic                 vld_r  [STEPS];

  logic signed [CW-1:0] cx_nxt  [STEPS];
  logic signed [CW-1:0] cy_nxt  [STEPS];
  logic signed [AW-1:0] acc_nxt [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    localparam logic [apt_pkg::ANG_W-1:0] ANG = apt_pkg::atan_udeg(i);

    logic signed [CW-1:0] cx_in;
    logic signed [CW-1:0] cy_in;
    logic signed [AW-1:0] acc_in;
    apt_pkg::meta_t       meta_in;
    logic                 vld_in;
    logic signed [AW-1:0] ang_s;

    if (i == 0) begin : g_first
      // Radius and x both carry eight fraction bits.
      assign cx_in   = $signed({{(CW - apt_pkg::ROOT_W){1'b0}}, in_root});
      assign cy_in   = $signed({{(CW - apt_pkg::AXIS_W - 8){in_x[apt_pkg::AXIS_W-1]}},
                                in_x, 8'b0});
      assign acc_in  = '0;
      assign meta_in = in_meta;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign cx_in   = cx_r[i-1];
      assign cy_in   = cy_r[i-1];
      assign acc_in  = acc_r[i-1];
      assign meta_in = meta_r[i-1];
      assign vld_in  = vld_r[i-1];
    end

    assign ang_s = $signed({{(AW - apt_pkg::ANG_W){1'b0}}, ANG});

    always_comb begin
      if (!cy_in[CW-1] && (cy_in != '0)) begin
        cx_nxt[i]  = cx_in + (cy_in >>> i);
        cy_nxt[i]  = cy_in - (cx_in >>> i);
        acc_nxt[i] = acc_in + ang_s;
      end else begin
        cx_nxt[i]  = cx_in - (cy_in >>> i);
        cy_nxt[i]  = cy_in + (cx_in >>> i);
        acc_nxt[i] = acc_in - ang_s;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cx_r[i]   <= cx_nxt[i];
        cy_r[i]   <= cy_nxt[i];
        acc_r[i]  <= acc_nxt[i];
        meta_r[i] <= meta_in;
      end
    end
  end

  assign out_vld  = vld_r[STEPS-1];
  assign out_acc  = acc_r[STEPS-1];
  assign out_meta = meta_r[STEPS-1];

endmodule

/* rtl/core/apt_round.sv */
// Micro-degrees to rounded hundredths, saturation, special cases and the tilt compare.
// The last stage is the block's output register.
module apt_round (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic signed [apt_pkg::ACC_W-1:0]  in_acc,
  input  apt_pkg::meta_t                    in_meta,
  input  logic [apt_pkg::THR_W-1:0]         threshold,
  output logic                              out_vld,
  output logic signed [apt_pkg::PITCH_W-1:0] out_pitch,
  output logic                              out_tilted
);

  localparam int MW = apt_pkg::MAG_W;
  localparam int QW = apt_pkg::Q_W;

  // Stage 1: magnitude plus half the divisor.
  logic [MW-1:0]  mag1_r, mag1_nxt;
  logic           neg1_r;
  apt_pkg::meta_t meta1_r;
  logic           vld1_r;
  logic [apt_pkg::ACC_W-1:0] abs_acc;

  // Stage 2: quotient estimate by reciprocal, low by at most one.
  logic [MW-1:0]   mag2_r;
  logic [QW-1:0]   q2_r, q2_nxt;
  logic            neg2_r;
  apt_pkg::meta_t  meta2_r;
  logic            vld2_r;
  logic [2*MW-1:0] prod;

  // Stage 3: correction and saturation.
  logic [QW-1:0]   q3_r, q3_nxt;
  logic            neg3_r;
  apt_pkg::meta_t  meta3_r;
  logic            vld3_r;
  logic [2*QW-1:0] back;
  logic [MW-1:0]   rem;
  logic [QW-1:0]   q_fix;

  // Stage 4: output register.
  logic                              vld4_r;
  logic signed [apt_pkg::PITCH_W-1:0] pitch4_r, pitch4_nxt;
  logic                              tilt4_r, tilt4_nxt;
  logic [QW-1:0]                     mag_out;

  always_comb begin
    abs_acc  = in_acc[apt_pkg::ACC_W-1] ? (-in_acc) : in_acc;
    mag1_nxt = abs_acc[MW-1:0] + apt_pkg::HALF_DIV;
  end

  always_comb begin
    prod   = {{MW{1'b0}}, mag1_r} * {{MW{1'b0}}, apt_pkg::RECIP};
    q2_nxt = prod[apt_pkg::RECIP_SHIFT +: QW];
  end

  always_comb begin
    back   = {{QW{1'b0}}, q2_r} * {{QW{1'b0}}, apt_pkg::DIVISOR};
    rem    = mag2_r - back[MW-1:0];
    q_fix  = (rem >= {{(MW - QW){1'b0}}, apt_pkg::DIVISOR}) ? (q2_r + 1'b1) : q2_r;
    q3_nxt = (q_fix > apt_pkg::PITCH_MAX) ? apt_pkg::PITCH_MAX : q_fix;
  end

  always_comb begin
    if (meta3_r.x_zero) begin
      mag_out    = '0;
      pitch4_nxt = '0;
    end else if (meta3_r.s_zero) begin
      mag_out    = apt_pkg::PITCH_MAX;
      pitch4_nxt = meta3_r.x_neg ? -$signed({1'b0, apt_pkg::PITCH_MAX})
                                 : $signed({1'b0, apt_pkg::PITCH_MAX});
    end else begin
      mag_out    = q3_r;
      pitch4_nxt = neg3_r ? -$signed({1'b0, q3_r}) : $signed({1'b0, q3_r});
    end
    tilt4_nxt = (mag_out > threshold);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1_r   <= mag1_nxt;
      neg1_r   <= in_acc[apt_pkg::ACC_W-1];
      meta1_r  <= in_meta;
      mag2_r   <= mag1_r;
      q2_r     <= q2_nxt;
      neg2_r   <= neg1_r;
      meta2_r  <= meta1_r;
      q3_r     <= q3_nxt;
      neg3_r   <= neg2_r;
      meta3_r  <= meta2_r;
      pitch4_r <= pitch4_nxt;
      tilt4_r  <= tilt4_nxt;
    end
  end

  assign out_vld    = vld4_r;
  assign out_pitch  = pitch4_r;
  assign out_tilted = tilt4_r;

endmodule

/* rtl/core/accel_pitch_tilt_detect_top.sv */
// Pitch and tilt from a three-axis accelerometer sample. Each input beat carries one signed
// sample; each output beat gives the pitch atan2(x, sqrt(y*y + z*z)) in signed hundredths of
// a degree, rounded to nearest and held within plus or minus 9000, together with a tilt flag
// that is set when the absolute pitch is strictly greater than the threshold register. An
// all-zero sample gives 0, a sample with x zero gives exactly 0, and one with y and z both
// zero gives exactly plus or minus 9000. The block takes one beat every clock cycle while the
// output is not held off: it is a single pipeline of 30 + ITERATIONS stages (46 with the
// default, ITERATIONS above 24 taken as 24), made up of two stages for the squares and their
// sum, one stage per root bit of the 24-bit square root, one stage per CORDIC micro-rotation
// and four stages for rounding, limiting and the threshold compare. Every stage advances
// whenever the output register is empty or being taken, so a stall on the output side holds
// the whole pipeline without losing or repeating a beat, and bubbles in the input stream
// pass through as empty stages. The threshold is written through cfg_wr_en and cfg_wr_data,
// resets to 4500 and should only be changed while no beat is in flight.
module accel_pitch_tilt_detect_top #(
  parameter int ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input sample: [15:0] accel_x, [31:16] accel_y, [47:32] accel_z.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  // Result: [14:0] pitch_angle, [15] tilted.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  // Threshold register write.
  input  logic        cfg_wr_en,
  input  logic [apt_pkg::THR_W-1:0] cfg_wr_data
);

  localparam int AW = apt_pkg::AXIS_W;

  // The whole pipeline moves together; it stops only when a result waits to be taken.
  logic en;

  logic [apt_pkg::THR_W-1:0] thr_r;

  // Stage A: squares of y and z.
  logic signed [AW-1:0]     ax, ay, az;
  logic signed [2*AW-1:0]   yy_full, zz_full;
  logic                     vld_a_r;
  logic signed [AW-1:0]     x_a_r;
  logic [apt_pkg::SQR_W-1:0] yy_a_r, zz_a_r;

  // Stage B: sum of squares and the special-case flags.
  logic [apt_pkg::SUM_W-1:0] sum_nxt;
  logic                      vld_b_r;
  logic [apt_pkg::SUM_W-1:0] sum_b_r;
  logic signed [AW-1:0]      x_b_r;
  apt_pkg::meta_t            meta_nxt, meta_b_r;

  logic                               sq_vld;
  logic [apt_pkg::ROOT_W-1:0]         sq_root;
  logic signed [AW-1:0]               sq_x;
  apt_pkg::meta_t                     sq_meta;

  logic                               cd_vld;
  logic signed [apt_pkg::ACC_W-1:0]   cd_acc;
  apt_pkg::meta_t                     cd_meta;

  logic signed [apt_pkg::PITCH_W-1:0] pitch;
  logic                               tilted;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= apt_pkg::THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  assign ax = $signed(in_tdata[AW-1:0]);
  assign ay = $signed(in_tdata[2*AW-1:AW]);
  assign az = $signed(in_tdata[3*AW-1:2*AW]);

  always_comb begin
    yy_full = ay * ay;
    zz_full = az * az;
  end

  always_comb begin
    sum_nxt         = {1'b0, yy_a_r} + {1'b0, zz_a_r};
    meta_nxt.x_zero = (x_a_r == '0);
    meta_nxt.s_zero = (sum_nxt == '0);
    meta_nxt.x_neg  = x_a_r[AW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_tvalid;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_a_r    <= ax;
      yy_a_r   <= yy_full[apt_pkg::SQR_W-1:0];
      zz_a_r   <= zz_full[apt_pkg::SQR_W-1:0];
      sum_b_r  <= sum_nxt;
      x_b_r    <= x_a_r;
      meta_b_r <= meta_nxt;
    end
  end

  apt_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld_b_r),
    .in_sum   (sum_b_r),
    .in_x     (x_b_r),
    .in_meta  (meta_b_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_x    (sq_x),
    .out_meta (sq_meta)
  );

  apt_cordic #(
    .ITERATIONS (ITERATIONS)
  ) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (sq_vld),
    .in_root  (sq_root),
    .in_x     (sq_x),
    .in_meta  (sq_meta),
    .out_vld  (cd_vld),
    .out_acc  (cd_acc),
    .out_meta (cd_meta)
  );

  apt_round u_round (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_vld     (cd_vld),
    .in_acc     (cd_acc),
    .in_meta    (cd_meta),
    .threshold  (thr_r),
    .out_vld    (out_tvalid),
    .out_pitch  (pitch),
    .out_tilted (tilted)
  );

  assign out_tdata = {tilted, pitch};

endmodule
